@@ rtl/bbp_pkg.sv @@
// ----------------------------------------------------------------------------
// bbp_pkg
// Shared types and constants of the BIOP binding parser: parse phases,
// status codes, the parser state word and the result word.
// ----------------------------------------------------------------------------
package bbp_pkg;

	// width of the saturating consumed-byte count
	localparam int LEN_W = 32;

	// offset of the object key length inside a BIOP profile body
	localparam logic [7:0] KEY_LEN_OFFSET = 8'd15;

	// most key bytes kept
	localparam logic [7:0] KEY_MAX_BYTES = 8'd4;

	// reset value of the BIOP profile tag register
	localparam logic [31:0] BIOP_TAG_RESET = 32'h4953_4F06;

	// record kinds
	localparam logic REC_ID    = 1'b0;
	localparam logic REC_FINAL = 1'b1;

	// final record status
	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_NAME_CNT = 3'd1,
		ST_BAD_KIND_LEN = 3'd2,
		ST_BAD_TYPE_LEN = 3'd3,
		ST_ZERO_KEY_LEN = 3'd4
	} bbp_status_t;

	// parse phases, one-hot
	typedef enum logic [13:0] {
		PH_IDLE       = 14'b00000000000001,
		PH_ID_LEN     = 14'b00000000000010,
		PH_ID_DATA    = 14'b00000000000100,
		PH_KIND_LEN   = 14'b00000000001000,
		PH_KIND       = 14'b00000000010000,
		PH_BIND_TYPE  = 14'b00000000100000,
		PH_TYPE_LEN   = 14'b00000001000000,
		PH_TYPE       = 14'b00000010000000,
		PH_PROF_COUNT = 14'b00000100000000,
		PH_TAG        = 14'b00001000000000,
		PH_PROF_LEN   = 14'b00010000000000,
		PH_BODY       = 14'b00100000000000,
		PH_OINFO_LEN  = 14'b01000000000000,
		PH_OINFO      = 14'b10000000000000
	} bbp_phase_t;

	// parser state carried from byte to byte
	typedef struct packed {
		bbp_phase_t       phase;
		logic [7:0]       cnt;        // byte count in field, saturates
		logic [31:0]      prof_left;
		logic [31:0]      tag_sh;     // tag / type length accumulator
		logic [31:0]      prof_rem;
		logic [7:0]       id_len;
		logic [7:0]       key_len;
		logic [31:0]      kind;
		logic [31:0]      typ;
		logic [31:0]      key;
		logic [LEN_W-1:0] consumed;
	} bbp_state_t;

	// parser state after reset
	localparam bbp_state_t STATE_IDLE = '{
		phase:     PH_IDLE,
		cnt:       8'd0,
		prof_left: 32'd0,
		tag_sh:    32'd0,
		prof_rem:  32'd0,
		id_len:    8'd0,
		key_len:   8'd0,
		kind:      32'd0,
		typ:       32'd0,
		key:       32'd0,
		consumed:  '0
	};

	// one result word
	typedef struct packed {
		logic        rec_kind;
		logic [7:0]  id_byte;
		bbp_status_t status;
		logic [31:0] kind_value;
		logic [31:0] type_value;
		logic [31:0] object_key;
		logic [31:0] total_length;
	} bbp_result_t;

endpackage

@@ rtl/bbp_step.sv @@
// ----------------------------------------------------------------------------
// bbp_step
// Next-state logic of the binding parser: takes the current parser state
// and one byte, gives the next state and at most one result word.
// ----------------------------------------------------------------------------
module bbp_step (
	input  bbp_pkg::bbp_state_t  cur,
	input  logic [7:0]           data_byte,
	input  logic                 first_byte,
	input  logic [31:0]          biop_tag,
	output bbp_pkg::bbp_state_t  nxt,
	output logic                 res_valid,
	output bbp_pkg::bbp_result_t res
);

	logic [7:0]  cnt_inc;
	logic [7:0]  cnt_sat;
	logic [8:0]  id_next;
	logic [31:0] acc_tag;
	logic [31:0] left_dec;
	logic [31:0] rem_dec;
	logic [15:0] oinfo_len;
	logic [7:0]  key_idx;
	logic [7:0]  key_lim;
	logic        is_biop;
	logic        fin;
	bbp_pkg::bbp_status_t fin_st;

	assign cnt_inc   = cur.cnt + 8'd1;
	assign cnt_sat   = (cur.cnt == 8'hff) ? cur.cnt : cnt_inc;
	assign id_next   = {1'b0, cur.cnt} + 9'd1;
	assign acc_tag   = {cur.tag_sh[23:0], data_byte};
	assign left_dec  = cur.prof_left - 32'd1;
	assign rem_dec   = cur.prof_rem - 32'd1;
	assign oinfo_len = {cur.prof_rem[7:0], data_byte};
	assign key_idx   = cur.cnt - bbp_pkg::KEY_LEN_OFFSET - 8'd1;
	assign key_lim   = (cur.key_len < bbp_pkg::KEY_MAX_BYTES) ? cur.key_len
		: bbp_pkg::KEY_MAX_BYTES;
	assign is_biop   = (cur.tag_sh == biop_tag);

	// one parse step
	always_comb begin
		nxt       = cur;
		fin       = 1'b0;
		fin_st    = bbp_pkg::ST_OK;
		res_valid = 1'b0;
		res       = '0;
		if (first_byte) begin
			nxt          = '0;
			nxt.phase    = bbp_pkg::PH_ID_LEN;
			nxt.consumed = bbp_pkg::LEN_W'(1);
			if (data_byte != 8'd1) begin
				fin    = 1'b1;
				fin_st = bbp_pkg::ST_BAD_NAME_CNT;
			end
		end else if (cur.phase != bbp_pkg::PH_IDLE) begin
			if (cur.consumed != '1) begin
				nxt.consumed = cur.consumed + bbp_pkg::LEN_W'(1);
			end
			case (cur.phase)
				bbp_pkg::PH_ID_LEN: begin
					nxt.id_len = data_byte;
					nxt.cnt    = '0;
					nxt.phase  = (data_byte == 8'd0) ? bbp_pkg::PH_KIND_LEN
						: bbp_pkg::PH_ID_DATA;
				end
				bbp_pkg::PH_ID_DATA: begin
					// every id byte but the last goes out
					if (id_next < {1'b0, cur.id_len}) begin
						res_valid   = 1'b1;
						res.rec_kind = bbp_pkg::REC_ID;
						res.id_byte  = data_byte;
					end
					nxt.cnt = cnt_inc;
					if (id_next >= {1'b0, cur.id_len}) begin
						nxt.cnt   = '0;
						nxt.phase = bbp_pkg::PH_KIND_LEN;
					end
				end
				bbp_pkg::PH_KIND_LEN: begin
					if (data_byte != 8'd4) begin
						fin    = 1'b1;
						fin_st = bbp_pkg::ST_BAD_KIND_LEN;
					end else begin
						nxt.cnt   = '0;
						nxt.phase = bbp_pkg::PH_KIND;
					end
				end
				bbp_pkg::PH_KIND: begin
					nxt.kind = {cur.kind[23:0], data_byte};
					nxt.cnt  = cnt_inc;
					if (cur.cnt == 8'd3) begin
						nxt.cnt   = '0;
						nxt.phase = bbp_pkg::PH_BIND_TYPE;
					end
				end
				bbp_pkg::PH_BIND_TYPE: begin
					nxt.tag_sh = '0;
					nxt.phase  = bbp_pkg::PH_TYPE_LEN;
				end
				bbp_pkg::PH_TYPE_LEN: begin
					nxt.tag_sh = acc_tag;
					nxt.cnt    = cnt_inc;
					if (cur.cnt == 8'd3) begin
						nxt.cnt = '0;
						if (acc_tag != 32'd4) begin
							fin    = 1'b1;
							fin_st = bbp_pkg::ST_BAD_TYPE_LEN;
						end else begin
							nxt.phase = bbp_pkg::PH_TYPE;
						end
					end
				end
				bbp_pkg::PH_TYPE: begin
					nxt.typ = {cur.typ[23:0], data_byte};
					nxt.cnt = cnt_inc;
					if (cur.cnt == 8'd3) begin
						nxt.cnt       = '0;
						nxt.prof_left = '0;
						nxt.phase     = bbp_pkg::PH_PROF_COUNT;
					end
				end
				bbp_pkg::PH_PROF_COUNT: begin
					nxt.prof_left = {cur.prof_left[23:0], data_byte};
					nxt.cnt       = cnt_inc;
					if (cur.cnt == 8'd3) begin
						nxt.cnt      = '0;
						nxt.tag_sh   = '0;
						nxt.prof_rem = '0;
						nxt.phase    = ({cur.prof_left[23:0], data_byte} == 32'd0)
							? bbp_pkg::PH_OINFO_LEN : bbp_pkg::PH_TAG;
					end
				end
				bbp_pkg::PH_TAG: begin
					nxt.tag_sh = acc_tag;
					nxt.cnt    = cnt_inc;
					if (cur.cnt == 8'd3) begin
						nxt.cnt      = '0;
						nxt.prof_rem = '0;
						nxt.phase    = bbp_pkg::PH_PROF_LEN;
					end
				end
				bbp_pkg::PH_PROF_LEN: begin
					nxt.prof_rem = {cur.prof_rem[23:0], data_byte};
					nxt.cnt      = cnt_inc;
					if (cur.cnt == 8'd3) begin
						nxt.cnt = '0;
						if ({cur.prof_rem[23:0], data_byte} == 32'd0) begin
							// empty profile ends at once
							nxt.prof_left = left_dec;
							nxt.prof_rem  = '0;
							if (left_dec == 32'd0) begin
								nxt.phase = bbp_pkg::PH_OINFO_LEN;
							end else begin
								nxt.tag_sh = '0;
								nxt.phase  = bbp_pkg::PH_TAG;
							end
						end else begin
							nxt.phase = bbp_pkg::PH_BODY;
						end
					end
				end
				bbp_pkg::PH_BODY: begin
					if (is_biop && cur.cnt == bbp_pkg::KEY_LEN_OFFSET) begin
						nxt.key_len = data_byte;
						nxt.key     = '0;
						if (data_byte == 8'd0) begin
							fin    = 1'b1;
							fin_st = bbp_pkg::ST_ZERO_KEY_LEN;
						end
					end else if (is_biop && cur.cnt > bbp_pkg::KEY_LEN_OFFSET) begin
						if (key_idx < key_lim) begin
							nxt.key = {cur.key[23:0], data_byte};
						end
					end
					if (!fin) begin
						nxt.cnt      = cnt_sat;
						nxt.prof_rem = rem_dec;
						if (rem_dec == 32'd0) begin
							// profile done
							nxt.prof_left = left_dec;
							nxt.cnt       = '0;
							if (left_dec == 32'd0) begin
								nxt.prof_rem = '0;
								nxt.phase    = bbp_pkg::PH_OINFO_LEN;
							end else begin
								nxt.tag_sh = '0;
								nxt.phase  = bbp_pkg::PH_TAG;
							end
						end
					end
				end
				bbp_pkg::PH_OINFO_LEN: begin
					nxt.prof_rem = {16'd0, oinfo_len};
					nxt.cnt      = cnt_inc;
					if (cur.cnt == 8'd1) begin
						nxt.cnt = '0;
						if (oinfo_len == 16'd0) begin
							fin = 1'b1;
						end else begin
							nxt.phase = bbp_pkg::PH_OINFO;
						end
					end
				end
				bbp_pkg::PH_OINFO: begin
					nxt.prof_rem = rem_dec;
					if (rem_dec == 32'd0) begin
						fin = 1'b1;
					end
				end
				default: begin
					nxt.phase = bbp_pkg::PH_IDLE;
				end
			endcase
		end

		// final record from the updated captures
		if (fin) begin
			nxt.phase        = bbp_pkg::PH_IDLE;
			res_valid        = 1'b1;
			res.rec_kind     = bbp_pkg::REC_FINAL;
			res.id_byte      = '0;
			res.status       = fin_st;
			res.kind_value   = nxt.kind;
			res.type_value   = nxt.typ;
			res.object_key   = nxt.key;
			res.total_length = (fin_st == bbp_pkg::ST_OK) ? 32'(nxt.consumed) : 32'd0;
		end
	end

endmodule

@@ rtl/biop_binding_parser.sv @@
// ----------------------------------------------------------------------------
// biop_binding_parser
// Byte-serial parser of one DSM-CC BIOP binding with id byte and final
// record output.
// ----------------------------------------------------------------------------
// Takes one binding byte per cycle on the s_ stream while m_ does not stall
// it (tuser marks the first byte of a binding) and gives id-byte words and
// one final word per binding on the m_ stream. Each byte is held in the input
// register and then one parse step of bbp_step moves its word into the output
// register, from which it is valid on m_. A byte can be taken every cycle
// while m_ does not stall; the rate is set by that single parse step. The
// user must write the profile tag register through the cfg_ channel only
// while no binding is in flight; the block itself does not enforce this.
module biop_binding_parser (
	input  logic          clk,
	input  logic          arst_n,
	// profile tag write
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [31:0]   cfg_data,
	// input bytes
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,  // [7:0] data_byte
	input  logic          s_tuser,  // [0] first_byte
	// result words
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [143:0]  m_tdata,  // [7:0] id_byte, [10:8] status,
	                                // [42:11] kind_value, [74:43] type_value,
	                                // [106:75] object_key, [138:107] total_length,
	                                // [143:139] zero
	output logic          m_tuser   // [0] record_kind
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  first_s1;
	logic [31:0]           tag_q;
	bbp_pkg::bbp_state_t   state_q;
	bbp_pkg::bbp_state_t   state_nxt;
	logic                  res_valid;
	bbp_pkg::bbp_result_t  res;
	bbp_pkg::bbp_result_t  out_q;
	logic                  out_valid_q;
	logic                  adv;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv;

	// profile tag register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= bbp_pkg::BIOP_TAG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tag_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	// parse step
	bbp_step u_step (
		.cur        (state_q),
		.data_byte  (byte_s1),
		.first_byte (first_s1),
		.biop_tag   (tag_q),
		.nxt        (state_nxt),
		.res_valid  (res_valid),
		.res        (res)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbp_pkg::STATE_IDLE;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.rec_kind;
	assign m_tdata  = {5'd0, out_q.total_length, out_q.object_key, out_q.type_value,
		out_q.kind_value, out_q.status, out_q.id_byte};

endmodule

@@ verif/biop_binding_parser_test.sv @@
// ----------------------------------------------------------------------------
// biop_binding_parser_test
// Self-checking bench for the byte-serial BIOP binding parser. Bindings are
// built byte by byte, well formed for the most part with random content, and
// mixed with broken ones, restarts and stray bytes. A parser model inside the
// bench turns each accepted byte into the id and final words it should cause.
// The output stream is compared word by word, field by field, in order. Both
// streams idle at random, and the profile tag register is rewritten between
// phases.
// ----------------------------------------------------------------------------
module biop_binding_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [31:0]   cfg_data  = '0;
	logic          s_tvalid  = 1'b0;
	logic          s_tready;
	logic [7:0]    s_tdata   = '0;  // [7:0] data_byte
	logic          s_tuser   = 1'b0;  // [0] first_byte
	logic          m_tvalid;
	logic          m_tready  = 1'b0;
	logic [143:0]  m_tdata;  // [7:0] id_byte, [10:8] status, [42:11] kind_value,
	                         // [74:43] type_value, [106:75] object_key,
	                         // [138:107] total_length, [143:139] zero
	logic          m_tuser;  // [0] record_kind

	biop_binding_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// expected output words, oldest first
	bbp_pkg::bbp_result_t pending_records[$];
	int fail_count      = 0;
	int bytes_sent      = 0;
	bit no_idle         = 1'b0;

	// binding under construction
	logic [7:0] frame[$];

	// parser model state
	logic [31:0]               biop_tag = bbp_pkg::BIOP_TAG_RESET;
	bbp_pkg::bbp_phase_t       ph       = bbp_pkg::PH_IDLE;
	logic [31:0]               fcnt, prof_left, tag_acc, prof_rem;
	logic [7:0]                id_len, key_len;
	logic [31:0]               kind_acc, type_acc, key_acc;
	logic [bbp_pkg::LEN_W-1:0] byte_total;

	function automatic bit pause_now();
		return !no_idle && ($urandom_range(99) < 14);
	endfunction

	// ------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------
	task automatic clear_parse();
		ph         = bbp_pkg::PH_IDLE;
		fcnt       = '0;
		prof_left  = '0;
		tag_acc    = '0;
		prof_rem   = '0;
		id_len     = '0;
		key_len    = '0;
		kind_acc   = '0;
		type_acc   = '0;
		key_acc    = '0;
		byte_total = '0;
	endtask

	task automatic close_binding(input bbp_pkg::bbp_status_t st);
		bbp_pkg::bbp_result_t r;
		r              = '0;
		r.rec_kind     = bbp_pkg::REC_FINAL;
		r.status       = st;
		r.kind_value   = kind_acc;
		r.type_value   = type_acc;
		r.object_key   = key_acc;
		r.total_length = (st == bbp_pkg::ST_OK) ? 32'(byte_total) : 32'd0;
		pending_records.push_back(r);
		ph = bbp_pkg::PH_IDLE;
	endtask

	task automatic leave_profile();
		prof_left--;
		fcnt = '0;
		if (prof_left == 0) begin
			prof_rem = '0;
			ph       = bbp_pkg::PH_OINFO_LEN;
		end else begin
			tag_acc = '0;
			ph      = bbp_pkg::PH_TAG;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic first);
		bbp_pkg::bbp_result_t r;
		logic [31:0] k, lim;
		logic hit;
		r = '0;
		// first byte restarts on the name component count
		if (first) begin
			clear_parse();
			byte_total = 1;
			if (b != 8'd1)
				close_binding(bbp_pkg::ST_BAD_NAME_CNT);
			else
				ph = bbp_pkg::PH_ID_LEN;
			return;
		end
		if (ph == bbp_pkg::PH_IDLE)
			return;
		if (byte_total != {bbp_pkg::LEN_W{1'b1}})
			byte_total++;
		case (ph)
			bbp_pkg::PH_ID_LEN: begin
				id_len = b;
				fcnt   = '0;
				ph     = (b == 8'd0) ? bbp_pkg::PH_KIND_LEN : bbp_pkg::PH_ID_DATA;
			end
			bbp_pkg::PH_ID_DATA: begin
				// every id byte but the last goes out
				if (fcnt + 1 < 32'(id_len)) begin
					r.rec_kind = bbp_pkg::REC_ID;
					r.id_byte  = b;
					pending_records.push_back(r);
				end
				fcnt++;
				if (fcnt >= 32'(id_len)) begin
					fcnt = '0;
					ph   = bbp_pkg::PH_KIND_LEN;
				end
			end
			bbp_pkg::PH_KIND_LEN: begin
				if (b != 8'd4) begin
					close_binding(bbp_pkg::ST_BAD_KIND_LEN);
					return;
				end
				fcnt = '0;
				ph   = bbp_pkg::PH_KIND;
			end
			bbp_pkg::PH_KIND: begin
				kind_acc = {kind_acc[23:0], b};
				fcnt++;
				if (fcnt == 4) begin
					fcnt = '0;
					ph   = bbp_pkg::PH_BIND_TYPE;
				end
			end
			bbp_pkg::PH_BIND_TYPE: begin
				tag_acc = '0;
				ph      = bbp_pkg::PH_TYPE_LEN;
			end
			bbp_pkg::PH_TYPE_LEN: begin
				tag_acc = {tag_acc[23:0], b};
				fcnt++;
				if (fcnt == 4) begin
					fcnt = '0;
					if (tag_acc != 32'd4) begin
						close_binding(bbp_pkg::ST_BAD_TYPE_LEN);
						return;
					end
					ph = bbp_pkg::PH_TYPE;
				end
			end
			bbp_pkg::PH_TYPE: begin
				type_acc = {type_acc[23:0], b};
				fcnt++;
				if (fcnt == 4) begin
					fcnt      = '0;
					prof_left = '0;
					ph        = bbp_pkg::PH_PROF_COUNT;
				end
			end
			bbp_pkg::PH_PROF_COUNT: begin
				prof_left = {prof_left[23:0], b};
				fcnt++;
				if (fcnt == 4) begin
					fcnt     = '0;
					tag_acc  = '0;
					prof_rem = '0;
					ph       = (prof_left == 0) ? bbp_pkg::PH_OINFO_LEN : bbp_pkg::PH_TAG;
				end
			end
			bbp_pkg::PH_TAG: begin
				tag_acc = {tag_acc[23:0], b};
				fcnt++;
				if (fcnt == 4) begin
					fcnt     = '0;
					prof_rem = '0;
					ph       = bbp_pkg::PH_PROF_LEN;
				end
			end
			bbp_pkg::PH_PROF_LEN: begin
				prof_rem = {prof_rem[23:0], b};
				fcnt++;
				if (fcnt == 4) begin
					fcnt = '0;
					if (prof_rem == 0)
						leave_profile();
					else
						ph = bbp_pkg::PH_BODY;
				end
			end
			bbp_pkg::PH_BODY: begin
				// key length and key bytes only in a BIOP profile
				hit = (tag_acc == biop_tag);
				if (hit && fcnt == 32'(bbp_pkg::KEY_LEN_OFFSET)) begin
					key_len = b;
					key_acc = '0;
					if (b == 8'd0) begin
						close_binding(bbp_pkg::ST_ZERO_KEY_LEN);
						return;
					end
				end else if (hit && fcnt > 32'(bbp_pkg::KEY_LEN_OFFSET)) begin
					k   = fcnt - 32'(bbp_pkg::KEY_LEN_OFFSET) - 1;
					lim = (key_len < bbp_pkg::KEY_MAX_BYTES) ? 32'(key_len)
						: 32'(bbp_pkg::KEY_MAX_BYTES);
					if (k < lim)
						key_acc = {key_acc[23:0], b};
				end
				fcnt++;
				prof_rem--;
				if (prof_rem == 0)
					leave_profile();
			end
			bbp_pkg::PH_OINFO_LEN: begin
				prof_rem = {16'h0, prof_rem[7:0], b};
				fcnt++;
				if (fcnt == 2) begin
					fcnt = '0;
					if (prof_rem == 0) begin
						close_binding(bbp_pkg::ST_OK);
						return;
					end
					ph = bbp_pkg::PH_OINFO;
				end
			end
			bbp_pkg::PH_OINFO: begin
				prof_rem--;
				if (prof_rem == 0)
					close_binding(bbp_pkg::ST_OK);
			end
			default: ph = bbp_pkg::PH_IDLE;
		endcase
	endtask

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic first);
		while (pause_now()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
		parse_byte(b, first);
		bytes_sent++;
	endtask

	// send the first cut bytes of the frame, then drop it
	task automatic send_frame(input int cut);
		for (int i = 0; i < frame.size() && i < cut; i++)
			send_byte(frame[i], i == 0);
		frame.delete();
	endtask

	// wait out every expected word and the pipeline behind it
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_tag(input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		biop_tag = v;
	endtask

	// ------------------------------------------------------------------
	// binding builders
	// ------------------------------------------------------------------
	task automatic add_u32(input logic [31:0] v);
		for (int i = 3; i >= 0; i--)
			frame.push_back(v[8*i +: 8]);
	endtask

	task automatic add_head(input logic [7:0] name_cnt, input logic [7:0] idl,
	                        input logic [7:0] kind_len, input logic [31:0] type_len);
		frame.push_back(name_cnt);
		frame.push_back(idl);
		repeat (idl) frame.push_back(8'($urandom));
		frame.push_back(kind_len);
		repeat (5) frame.push_back(8'($urandom));  // kind, binding type
		add_u32(type_len);
		repeat (4) frame.push_back(8'($urandom));
	endtask

	function automatic int biop_full(input int klen);
		return int'(bbp_pkg::KEY_LEN_OFFSET) + 1 + klen + $urandom_range(3);
	endfunction

	task automatic add_biop(input logic [31:0] tag, input int klen, input int len);
		add_u32(tag);
		add_u32(len);
		for (int j = 0; j < len; j++)
			frame.push_back((j == int'(bbp_pkg::KEY_LEN_OFFSET)) ? 8'(klen)
				: 8'($urandom));
	endtask

	task automatic add_plain(input logic [31:0] tag, input int len);
		add_u32(tag);
		add_u32(len);
		repeat (len) frame.push_back(8'($urandom));
	endtask

	task automatic add_tail(input logic [15:0] oinfo_len);
		frame.push_back(oinfo_len[15:8]);
		frame.push_back(oinfo_len[7:0]);
		repeat (oinfo_len) frame.push_back(8'($urandom));
	endtask

	task automatic good_binding(input logic [7:0] idl, input int klen);
		add_head(8'd1, idl, 8'd4, 32'd4);
		add_u32(1);
		add_biop(biop_tag, klen, biop_full(klen));
		add_tail(16'd2);
		send_frame(frame.size());
	endtask

	task automatic random_binding();
		int n_prof, klen, len, cut;
		logic [31:0] tag;
		logic [7:0] name_cnt, kind_len, idl;
		logic [31:0] type_len;
		logic [15:0] oinfo;
		name_cnt = ($urandom_range(99) < 3) ? 8'($urandom) : 8'd1;
		kind_len = ($urandom_range(99) < 3) ? 8'($urandom) : 8'd4;
		type_len = ($urandom_range(99) < 3) ? $urandom : 32'd4;
		idl      = ($urandom_range(99) < 5) ? 8'($urandom_range(7, 40)) : 8'($urandom_range(6));
		n_prof   = ($urandom_range(99) < 70) ? $urandom_range(1, 2) : $urandom_range(4);
		oinfo    = ($urandom_range(99) < 5) ? 16'($urandom_range(100, 300))
		                                    : 16'($urandom_range(6));
		add_head(name_cnt, idl, kind_len, type_len);
		add_u32(n_prof);
		for (int p = 0; p < n_prof; p++) begin
			if ($urandom_range(99) < 60) begin
				klen = ($urandom_range(99) < 6) ? 0 : $urandom_range(1, 7);
				len  = biop_full(klen);
				if ($urandom_range(99) < 15)
					len = $urandom_range(1, len - 1);
				add_biop(biop_tag, klen, len);
			end else begin
				// unrelated tag or one bit away from the BIOP tag
				tag = $urandom_range(1) ? $urandom : (biop_tag ^ (32'd1 << $urandom_range(31)));
				add_plain(tag, $urandom_range(10));
			end
		end
		add_tail(oinfo);
		cut = ($urandom_range(99) < 8) ? $urandom_range(1, frame.size() - 1) : frame.size();
		send_frame(cut);
		// stray bytes, mostly landing on an idle parser
		if ($urandom_range(99) < 6)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
		if ($urandom_range(99) < 3)
			send_byte(8'($urandom), 1'b1);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// tag register out of reset marks BIOP profiles
	task automatic test_reset_tag();
		good_binding(8'd3, 4);
		good_binding(8'd0, 2);
		good_binding(8'd1, 1);
	endtask

	task automatic test_error_status();
		// bad name count; the bytes after it hit an idle parser
		add_head(8'd0, 8'd2, 8'd4, 32'd4);
		send_frame(3);
		add_head(8'hFF, 8'd2, 8'd4, 32'd4);
		send_frame(3);
		// bad kind length
		add_head(8'd1, 8'd2, 8'd0, 32'd4);
		send_frame(frame.size());
		add_head(8'd1, 8'd2, 8'd5, 32'd4);
		send_frame(frame.size());
		// bad type id length
		add_head(8'd1, 8'd2, 8'd4, 32'd5);
		send_frame(frame.size());
		add_head(8'd1, 8'd2, 8'd4, 32'h0400_0000);
		send_frame(frame.size());
		// zero key length
		add_head(8'd1, 8'd2, 8'd4, 32'd4);
		add_u32(1);
		add_biop(biop_tag, 0, biop_full(0));
		add_tail(16'd0);
		send_frame(frame.size());
		// bytes while idle
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
	endtask

	task automatic test_profile_walk();
		// restart in the middle of a binding
		add_head(8'd1, 8'd2, 8'd4, 32'd4);
		add_u32(1);
		add_biop(biop_tag, 4, biop_full(4));
		add_tail(16'd1);
		send_frame(20);
		good_binding(8'd2, 3);
		// BIOP body ends before the key length byte
		add_head(8'd1, 8'd1, 8'd4, 32'd4);
		add_u32(1);
		add_biop(biop_tag, 4, 10);
		add_tail(16'd0);
		send_frame(frame.size());
		// BIOP body ends inside the key
		add_head(8'd1, 8'd1, 8'd4, 32'd4);
		add_u32(1);
		add_biop(biop_tag, 4, 18);
		add_tail(16'd0);
		send_frame(frame.size());
		// key longer than four bytes
		good_binding(8'd2, 7);
		// several profiles, the last BIOP key wins
		add_head(8'd1, 8'd2, 8'd4, 32'd4);
		add_u32(3);
		add_biop(biop_tag, 3, biop_full(3));
		add_plain($urandom, 5);
		add_biop(biop_tag, 4, biop_full(4));
		add_tail(16'd3);
		send_frame(frame.size());
		// no profiles, empty object info
		add_head(8'd1, 8'd0, 8'd4, 32'd4);
		add_u32(0);
		add_tail(16'd0);
		send_frame(frame.size());
		// empty profile ahead of a BIOP one
		add_head(8'd1, 8'd2, 8'd4, 32'd4);
		add_u32(2);
		add_plain(biop_tag, 0);
		add_biop(biop_tag, 2, biop_full(2));
		add_tail(16'd1);
		send_frame(frame.size());
		// longest id
		add_head(8'd1, 8'd255, 8'd4, 32'd4);
		add_u32(0);
		add_tail(16'd1);
		send_frame(frame.size());
	endtask

	// extreme tags: the old reset tag no longer marks a BIOP profile
	task automatic test_tag_register();
		logic [31:0] v;
		for (int i = 0; i < 2; i++) begin
			v = (i == 0) ? 32'h0 : 32'hFFFF_FFFF;
			settle();
			write_tag(v);
			add_head(8'd1, 8'd2, 8'd4, 32'd4);
			add_u32(2);
			add_plain(bbp_pkg::BIOP_TAG_RESET, 20);
			add_biop(v, 4, biop_full(4));
			add_tail(16'd1);
			send_frame(frame.size());
		end
		settle();
		write_tag(bbp_pkg::BIOP_TAG_RESET);
		good_binding(8'd2, 4);
	endtask

	task automatic test_random_bindings();
		logic [31:0] tag;
		int start_bytes;
		for (int i = 0; i < 4; i++) begin
			case (i)
				1:       tag = 32'hFFFF_FFFF;
				2:       tag = 32'h0;
				default: tag = $urandom;
			endcase
			settle();
			write_tag(tag);
			// one phase runs with no idling on either side
			no_idle     = (i == 2);
			start_bytes = bytes_sent;
			while (bytes_sent - start_bytes < 40)
				random_binding();
		end
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// output side: stall at random, check each word against the model
	// ------------------------------------------------------------------
	always @(posedge clk)
		m_tready <= !pause_now();

	task automatic note_mismatch(input string what, input logic [31:0] want,
	                             input logic [31:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin : check_word
		bbp_pkg::bbp_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_records.size() == 0) begin
				note_mismatch("unexpected word, tdata low", 32'h0, m_tdata[31:0]);
			end else begin
				want = pending_records.pop_front();
				if (m_tuser !== want.rec_kind)
					note_mismatch("record_kind", 32'(want.rec_kind), 32'(m_tuser));
				if (m_tdata[7:0] !== want.id_byte)
					note_mismatch("id_byte", 32'(want.id_byte), 32'(m_tdata[7:0]));
				if (m_tdata[10:8] !== want.status)
					note_mismatch("status", 32'(want.status), 32'(m_tdata[10:8]));
				if (m_tdata[42:11] !== want.kind_value)
					note_mismatch("kind_value", want.kind_value, m_tdata[42:11]);
				if (m_tdata[74:43] !== want.type_value)
					note_mismatch("type_value", want.type_value, m_tdata[74:43]);
				if (m_tdata[106:75] !== want.object_key)
					note_mismatch("object_key", want.object_key, m_tdata[106:75]);
				if (m_tdata[138:107] !== want.total_length)
					note_mismatch("total_length", want.total_length, m_tdata[138:107]);
				if (m_tdata[143:139] !== 5'd0)
					note_mismatch("pad bits", 32'h0, 32'(m_tdata[143:139]));
			end
		end
	end

	// ends the run when no word moves on any channel for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		clear_parse();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_tag();
		test_error_status();
		test_profile_walk();
		test_tag_register();
		test_random_bindings();
		settle();
		if (fail_count == 0 && pending_records.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
